[hw/rtl/ect_pkg.sv]
`default_nettype none

package ect_pkg;

  localparam int CW = 16;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLOSE  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] ST_TRIANGLE = 3'd0;
  localparam logic [2:0] ST_INSIDE   = 3'd1;
  localparam logic [2:0] ST_OUTSIDE  = 3'd2;
  localparam logic [2:0] ST_NO_EAR   = 3'd3;
  localparam logic [2:0] ST_TOO_FEW  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  typedef struct packed {
    logic [1:0]           opcode;
    logic signed [CW-1:0] x_coord;
    logic signed [CW-1:0] y_coord;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] middle_x;
    logic signed [CW-1:0] middle_y;
    logic signed [CW-1:0] third_x;
    logic signed [CW-1:0] third_y;
    logic                 last_of_run;
  } rsp_t;

  // which orientation test the cross unit evaluates
  typedef enum logic [1:0] {
    SEL_CCW = 2'd0,
    SEL_E01 = 2'd1,
    SEL_E12 = 2'd2,
    SEL_E20 = 2'd3
  } sel_t;

  typedef struct packed {
    logic       vtx_we;
    logic       nxt_we;
    logic       prv_we;
    logic       tri_we;
    logic       load_c0;
    logic       load_c1;
    logic       load_c2;
    logic       load_pt_vtx;
    logic       load_pt_req;
    sel_t       cross_sel;
    logic       out_load;
    logic [2:0] out_status;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic cross_pos;
    logic cross_neg;
    logic same_any;
  } stat_t;

endpackage

`default_nettype wire

[hw/rtl/ect_ram.sv]
`default_nettype none

module ect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/ect_datapath.sv]
`default_nettype none

module ect_datapath
  import ect_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  wire logic                                clk,
  input  wire cmd_t                                cmd,
  input  wire req_t                                req,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]     vtx_waddr,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]     vtx_raddr,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]     nxt_waddr,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]     nxt_wdata,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]     prv_waddr,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]     prv_wdata,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]     lnk_raddr,
  input  wire logic [$clog2(MAX_VERTICES-2)-1:0]   tri_waddr,
  input  wire logic [3*$clog2(MAX_VERTICES)-1:0]   tri_wdata,
  input  wire logic [$clog2(MAX_VERTICES-2)-1:0]   tri_raddr,
  output logic      [$clog2(MAX_VERTICES)-1:0]     nxt_rdata,
  output logic      [$clog2(MAX_VERTICES)-1:0]     prv_rdata,
  output logic      [3*$clog2(MAX_VERTICES)-1:0]   tri_rdata,
  output stat_t                                    stat,
  output rsp_t                                     rsp
);

  localparam int IW       = $clog2(MAX_VERTICES);
  localparam int TRI_DEPTH = MAX_VERTICES - 2;
  localparam int PW       = 2 * CW + 2;

  logic [2*CW-1:0] vtx_rdata;

  logic signed [CW-1:0] c0x, c0y, c1x, c1y, c2x, c2y, ptx, pty;
  logic signed [CW-1:0] px, py, ax, ay, bx, by;
  logic signed [CW:0]   ux, uy, vx, vy;
  logic signed [PW-1:0] prod1, prod2;
  logic signed [PW:0]   diff;
  logic                 is_tri;

  ect_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTICES)) u_vtx_ram (
    .clk   (clk),
    .we    (cmd.vtx_we),
    .waddr (vtx_waddr),
    .wdata ({req.x_coord, req.y_coord}),
    .raddr (vtx_raddr),
    .rdata (vtx_rdata)
  );

  ect_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_nxt_ram (
    .clk   (clk),
    .we    (cmd.nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (lnk_raddr),
    .rdata (nxt_rdata)
  );

  ect_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_prv_ram (
    .clk   (clk),
    .we    (cmd.prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (lnk_raddr),
    .rdata (prv_rdata)
  );

  ect_ram #(.WIDTH(3 * IW), .DEPTH(TRI_DEPTH)) u_tri_ram (
    .clk   (clk),
    .we    (cmd.tri_we),
    .waddr (tri_waddr),
    .wdata (tri_wdata),
    .raddr (tri_raddr),
    .rdata (tri_rdata)
  );

  // corner and test point registers
  always_ff @(posedge clk) begin
    if (cmd.load_c0) begin
      c0x <= vtx_rdata[2*CW-1:CW];
      c0y <= vtx_rdata[CW-1:0];
    end
    if (cmd.load_c1) begin
      c1x <= vtx_rdata[2*CW-1:CW];
      c1y <= vtx_rdata[CW-1:0];
    end
    if (cmd.load_c2) begin
      c2x <= vtx_rdata[2*CW-1:CW];
      c2y <= vtx_rdata[CW-1:0];
    end
    if (cmd.load_pt_vtx) begin
      ptx <= vtx_rdata[2*CW-1:CW];
      pty <= vtx_rdata[CW-1:0];
    end else if (cmd.load_pt_req) begin
      ptx <= req.x_coord;
      pty <= req.y_coord;
    end
  end

  // operand select: point, edge start, edge end
  always_comb begin
    unique case (cmd.cross_sel)
      SEL_CCW: begin
        px = c1x; py = c1y; ax = c0x; ay = c0y; bx = c2x; by = c2y;
      end
      SEL_E01: begin
        px = ptx; py = pty; ax = c0x; ay = c0y; bx = c1x; by = c1y;
      end
      SEL_E12: begin
        px = ptx; py = pty; ax = c1x; ay = c1y; bx = c2x; by = c2y;
      end
      default: begin
        px = ptx; py = pty; ax = c2x; ay = c2y; bx = c0x; by = c0y;
      end
    endcase
    ux = (CW+1)'(px) - (CW+1)'(ax);
    uy = (CW+1)'(py) - (CW+1)'(ay);
    vx = (CW+1)'(bx) - (CW+1)'(ax);
    vy = (CW+1)'(by) - (CW+1)'(ay);
  end

  always_ff @(posedge clk) begin
    prod1 <= ux * vy;
    prod2 <= uy * vx;
  end

  assign diff = (PW+1)'(prod1) - (PW+1)'(prod2);

  assign stat.cross_neg = diff[PW];
  assign stat.cross_pos = !diff[PW] && (diff != '0);
  assign stat.same_any  = (ptx == c0x && pty == c0y) || (ptx == c1x && pty == c1y) ||
                          (ptx == c2x && pty == c2y);

  assign is_tri = (cmd.out_status == ST_TRIANGLE);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status      <= cmd.out_status;
      rsp.first_x     <= is_tri ? c0x : '0;
      rsp.first_y     <= is_tri ? c0y : '0;
      rsp.middle_x    <= is_tri ? c1x : '0;
      rsp.middle_y    <= is_tri ? c1y : '0;
      rsp.third_x     <= is_tri ? c2x : '0;
      rsp.third_y     <= is_tri ? c2y : '0;
      rsp.last_of_run <= cmd.out_last;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ect_ctrl.sv]
`default_nettype none

module ect_ctrl
  import ect_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire req_t                              req,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_ready,
  output cmd_t                                   cmd,
  input  wire stat_t                             stat,
  output logic [$clog2(MAX_VERTICES)-1:0]        vtx_waddr,
  output logic [$clog2(MAX_VERTICES)-1:0]        vtx_raddr,
  output logic [$clog2(MAX_VERTICES)-1:0]        nxt_waddr,
  output logic [$clog2(MAX_VERTICES)-1:0]        nxt_wdata,
  output logic [$clog2(MAX_VERTICES)-1:0]        prv_waddr,
  output logic [$clog2(MAX_VERTICES)-1:0]        prv_wdata,
  output logic [$clog2(MAX_VERTICES)-1:0]        lnk_raddr,
  output logic [$clog2(MAX_VERTICES-2)-1:0]      tri_waddr,
  output logic [3*$clog2(MAX_VERTICES)-1:0]      tri_wdata,
  output logic [$clog2(MAX_VERTICES-2)-1:0]      tri_raddr,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]   nxt_rdata,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]   prv_rdata,
  input  wire logic [3*$clog2(MAX_VERTICES)-1:0] tri_rdata
);

  localparam int IW        = $clog2(MAX_VERTICES);
  localparam int VCW       = $clog2(MAX_VERTICES + 1);
  localparam int TRI_DEPTH = MAX_VERTICES - 2;
  localparam int TIW       = $clog2(TRI_DEPTH);
  localparam int TCW       = $clog2(TRI_DEPTH + 1);

  typedef enum logic [20:0] {
    S_IDLE   = 21'd1 << 0,
    S_OUT    = 21'd1 << 1,
    S_INIT   = 21'd1 << 2,
    S_CORNER = 21'd1 << 3,
    S_LINK   = 21'd1 << 4,
    S_LDP    = 21'd1 << 5,
    S_LDI    = 21'd1 << 6,
    S_LDQ    = 21'd1 << 7,
    S_CCW    = 21'd1 << 8,
    S_CCWR   = 21'd1 << 9,
    S_KCHK   = 21'd1 << 10,
    S_KLD    = 21'd1 << 11,
    S_E01    = 21'd1 << 12,
    S_E12    = 21'd1 << 13,
    S_E20    = 21'd1 << 14,
    S_E20R   = 21'd1 << 15,
    S_Q_RDT  = 21'd1 << 16,
    S_Q_LDT  = 21'd1 << 17,
    S_Q_LA   = 21'd1 << 18,
    S_Q_LB   = 21'd1 << 19,
    S_Q_LC   = 21'd1 << 20
  } state_t;

  state_t         state, state_next, ret, ret_next;
  logic [VCW-1:0] vcount, vcount_next, size, size_next, misses, misses_next;
  logic [TCW-1:0] tcount, tcount_next, t, t_next;
  logic           closed, closed_next, qmode, qmode_next;
  logic           outside, outside_next, rsp_valid_next;
  logic [IW-1:0]  i, i_next, p, p_next, q, q_next, k, k_next;
  logic [IW-1:0]  tb, tb_next, tc, tc_next;
  logic [2:0]     emit_status, emit_status_next;
  logic           emit_last, emit_last_next;
  logic [VCW-1:0] vc_base;
  logic           do_ear, do_miss, do_store, pt_in;

  assign req_ready = (state == S_IDLE);
  assign vc_base   = closed ? '0 : vcount;
  assign pt_in     = !outside && !stat.cross_pos;

  always_comb begin
    state_next       = state;
    ret_next         = ret;
    vcount_next      = vcount;
    tcount_next      = tcount;
    closed_next      = closed;
    qmode_next       = qmode;
    size_next        = size;
    misses_next      = misses;
    t_next           = t;
    outside_next     = outside;
    i_next           = i;
    p_next           = p;
    q_next           = q;
    k_next           = k;
    tb_next          = tb;
    tc_next          = tc;
    emit_status_next = emit_status;
    emit_last_next   = emit_last;
    cmd              = '0;
    vtx_waddr        = vc_base[IW-1:0];
    vtx_raddr        = i;
    lnk_raddr        = i;
    nxt_waddr        = p;
    nxt_wdata        = q;
    prv_waddr        = q;
    prv_wdata        = p;
    tri_waddr        = tcount[TIW-1:0];
    tri_wdata        = {p, i, q};
    tri_raddr        = t[TIW-1:0];
    do_ear           = 1'b0;
    do_miss          = 1'b0;
    do_store         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.opcode)
            OP_CLEAR: begin
              vcount_next = '0;
              tcount_next = '0;
              closed_next = 1'b0;
            end
            OP_QUERY: begin
              cmd.load_pt_req = 1'b1;
              qmode_next      = 1'b1;
              t_next          = '0;
              if (tcount == '0) begin
                emit_status_next = ST_OUTSIDE;
                emit_last_next   = 1'b1;
                ret_next         = S_IDLE;
                state_next       = S_OUT;
              end else begin
                state_next = S_Q_RDT;
              end
            end
            default: begin
              // append: a closed polygon is dropped first
              if (closed) begin
                tcount_next = '0;
              end
              closed_next = 1'b0;
              vcount_next = vc_base;
              if (vc_base == VCW'(MAX_VERTICES)) begin
                emit_status_next = ST_OVERFLOW;
                emit_last_next   = 1'b1;
                ret_next         = S_IDLE;
                state_next       = S_OUT;
                if (req.opcode == OP_CLOSE) begin
                  tcount_next = '0;
                  closed_next = 1'b1;
                end
              end else begin
                cmd.vtx_we  = 1'b1;
                vcount_next = vc_base + VCW'(1);
                if (req.opcode == OP_CLOSE) begin
                  tcount_next = '0;
                  closed_next = 1'b1;
                  if (vc_base < VCW'(2)) begin
                    emit_status_next = ST_TOO_FEW;
                    emit_last_next   = 1'b1;
                    ret_next         = S_IDLE;
                    state_next       = S_OUT;
                  end else begin
                    size_next  = vc_base + VCW'(1);
                    k_next     = '0;
                    qmode_next = 1'b0;
                    state_next = S_INIT;
                  end
                end
              end
            end
          endcase
        end
      end
      S_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = emit_status;
          cmd.out_last   = emit_last;
          state_next     = ret;
        end
      end
      S_INIT: begin
        // one ring entry per cycle
        cmd.nxt_we = 1'b1;
        cmd.prv_we = 1'b1;
        nxt_waddr  = k;
        prv_waddr  = k;
        nxt_wdata  = (VCW'(k) + VCW'(1) == size) ? '0 : IW'(VCW'(k) + VCW'(1));
        prv_wdata  = (k == '0) ? IW'(size - VCW'(1)) : k - IW'(1);
        if (VCW'(k) + VCW'(1) == size) begin
          i_next      = '0;
          misses_next = '0;
          state_next  = S_CORNER;
        end else begin
          k_next = k + IW'(1);
        end
      end
      S_CORNER: begin
        lnk_raddr  = i;
        state_next = S_LINK;
      end
      S_LINK: begin
        p_next     = prv_rdata;
        q_next     = nxt_rdata;
        vtx_raddr  = prv_rdata;
        state_next = S_LDP;
      end
      S_LDP: begin
        cmd.load_c0 = 1'b1;
        vtx_raddr   = i;
        state_next  = S_LDI;
      end
      S_LDI: begin
        cmd.load_c1 = 1'b1;
        vtx_raddr   = q;
        lnk_raddr   = q;
        state_next  = S_LDQ;
      end
      S_LDQ: begin
        cmd.load_c2 = 1'b1;
        k_next      = nxt_rdata;
        if (size == VCW'(3)) begin
          do_store         = 1'b1;
          emit_status_next = ST_TRIANGLE;
          emit_last_next   = 1'b1;
          ret_next         = S_IDLE;
          state_next       = S_OUT;
        end else begin
          state_next = S_CCW;
        end
      end
      S_CCW: begin
        cmd.cross_sel = SEL_CCW;
        state_next    = S_CCWR;
      end
      S_CCWR: begin
        if (stat.cross_neg) begin
          do_miss = 1'b1;
        end else begin
          state_next = S_KCHK;
        end
      end
      S_KCHK: begin
        if (k == p) begin
          do_ear = 1'b1;
        end else begin
          vtx_raddr  = k;
          lnk_raddr  = k;
          state_next = S_KLD;
        end
      end
      S_KLD: begin
        cmd.load_pt_vtx = 1'b1;
        k_next          = nxt_rdata;
        state_next      = S_E01;
      end
      S_E01: begin
        cmd.cross_sel = SEL_E01;
        state_next    = S_E12;
      end
      S_E12: begin
        cmd.cross_sel = SEL_E12;
        outside_next  = stat.cross_pos;
        state_next    = S_E20;
      end
      S_E20: begin
        cmd.cross_sel = SEL_E20;
        outside_next  = outside || stat.cross_pos;
        state_next    = S_E20R;
      end
      S_E20R: begin
        if (qmode) begin
          if (pt_in) begin
            emit_status_next = ST_INSIDE;
            emit_last_next   = 1'b1;
            ret_next         = S_IDLE;
            state_next       = S_OUT;
          end else if (t + TCW'(1) == tcount) begin
            emit_status_next = ST_OUTSIDE;
            emit_last_next   = 1'b1;
            ret_next         = S_IDLE;
            state_next       = S_OUT;
          end else begin
            t_next     = t + TCW'(1);
            state_next = S_Q_RDT;
          end
        end else if (pt_in && !stat.same_any) begin
          do_miss = 1'b1;
        end else begin
          state_next = S_KCHK;
        end
      end
      S_Q_RDT: begin
        tri_raddr  = t[TIW-1:0];
        state_next = S_Q_LDT;
      end
      S_Q_LDT: begin
        vtx_raddr  = tri_rdata[3*IW-1:2*IW];
        tb_next    = tri_rdata[2*IW-1:IW];
        tc_next    = tri_rdata[IW-1:0];
        state_next = S_Q_LA;
      end
      S_Q_LA: begin
        cmd.load_c0 = 1'b1;
        vtx_raddr   = tb;
        state_next  = S_Q_LB;
      end
      S_Q_LB: begin
        cmd.load_c1 = 1'b1;
        vtx_raddr   = tc;
        state_next  = S_Q_LC;
      end
      S_Q_LC: begin
        cmd.load_c2 = 1'b1;
        state_next  = S_E01;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // ear found: unlink the tip and step back to the previous neighbor
    if (do_ear) begin
      do_store         = 1'b1;
      cmd.nxt_we       = 1'b1;
      cmd.prv_we       = 1'b1;
      size_next        = size - VCW'(1);
      misses_next      = '0;
      i_next           = p;
      emit_status_next = ST_TRIANGLE;
      emit_last_next   = 1'b0;
      ret_next         = S_CORNER;
      state_next       = S_OUT;
    end

    if (do_miss) begin
      if (misses + VCW'(1) >= size) begin
        emit_status_next = ST_NO_EAR;
        emit_last_next   = 1'b1;
        ret_next         = S_IDLE;
        state_next       = S_OUT;
      end else begin
        misses_next = misses + VCW'(1);
        i_next      = q;
        state_next  = S_CORNER;
      end
    end

    if (do_store && tcount < TCW'(TRI_DEPTH)) begin
      cmd.tri_we  = 1'b1;
      tcount_next = tcount + TCW'(1);
    end
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
    if (cmd.out_load) begin
      rsp_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      vcount    <= '0;
      tcount    <= '0;
      closed    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      vcount    <= vcount_next;
      tcount    <= tcount_next;
      closed    <= closed_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    qmode       <= qmode_next;
    size        <= size_next;
    misses      <= misses_next;
    t           <= t_next;
    outside     <= outside_next;
    i           <= i_next;
    p           <= p_next;
    q           <= q_next;
    k           <= k_next;
    tb          <= tb_next;
    tc          <= tc_next;
    emit_status <= emit_status_next;
    emit_last   <= emit_last_next;
  end

endmodule

`default_nettype wire

[hw/rtl/ear_clipping_triangulator.sv]
`default_nettype none
// a query reads each stored triangle in turn and tests the point against its edges,
// stopping at the first hit; the shared cross-product unit and the single read port of
// the vertex memory set the pace; triangulation links the ring, then at each corner tests
// convexity and every other live vertex against the ear, and clips each ear it finds
// one request in flight at a time; results leave through a one-entry output register
// reset (rst, synchronous) empties the polygon and triangle list; memories are not cleared

module ear_clipping_triangulator
  import ect_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int TIW = $clog2(MAX_VERTICES - 2);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // memory addresses and data between sequencer and datapath
  logic [IW-1:0]   vtx_waddr, vtx_raddr, lnk_raddr;
  logic [IW-1:0]   nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
  logic [IW-1:0]   nxt_rdata, prv_rdata;
  logic [TIW-1:0]  tri_waddr, tri_raddr;
  logic [3*IW-1:0] tri_wdata, tri_rdata;

  // sequencer: vertex count, ring walk, ear decisions, result ordering
  ect_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat),
    .vtx_waddr (vtx_waddr),
    .vtx_raddr (vtx_raddr),
    .nxt_waddr (nxt_waddr),
    .nxt_wdata (nxt_wdata),
    .prv_waddr (prv_waddr),
    .prv_wdata (prv_wdata),
    .lnk_raddr (lnk_raddr),
    .tri_waddr (tri_waddr),
    .tri_wdata (tri_wdata),
    .tri_raddr (tri_raddr),
    .nxt_rdata (nxt_rdata),
    .prv_rdata (prv_rdata),
    .tri_rdata (tri_rdata)
  );

  // datapath: vertex, link and triangle memories, corner registers,
  // registered exact cross-product sign unit, output register
  ect_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .req       (req),
    .vtx_waddr (vtx_waddr),
    .vtx_raddr (vtx_raddr),
    .nxt_waddr (nxt_waddr),
    .nxt_wdata (nxt_wdata),
    .prv_waddr (prv_waddr),
    .prv_wdata (prv_wdata),
    .lnk_raddr (lnk_raddr),
    .tri_waddr (tri_waddr),
    .tri_wdata (tri_wdata),
    .tri_raddr (tri_raddr),
    .nxt_rdata (nxt_rdata),
    .prv_rdata (prv_rdata),
    .tri_rdata (tri_rdata),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

[tb/tb_ear_clipping_triangulator.sv]
`timescale 1ns / 1ps

module tb_ear_clipping_triangulator;
  import ect_pkg::*;

  localparam int NV = 32;           // vertex store depth of the block
  localparam int NT = NV - 2;       // triangle store depth
  localparam int N_ITEMS = 480;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;

  // polygon predictor and expected-result store
  class triangle_board;
    int vx[NV], vy[NV], prv[NV], nxt[NV];
    int ta[NT], tb[NT], tc[NT];
    int vcount, tcount;
    bit closed;
    rsp_t pending[$];
    int errors, results, seen[8];

    function void clear_all();
      vcount = 0;
      tcount = 0;
      closed = 0;
    endfunction

    // sign of cross(p - a, b - a); exact in 64 bits for 16-bit coordinates
    function longint edge_side(int px, int py, int a, int b);
      longint ux, uy, wx, wy;
      ux = px - vx[a];
      uy = py - vy[a];
      wx = vx[b] - vx[a];
      wy = vy[b] - vy[a];
      return ux * wy - uy * wx;
    endfunction

    // edges and corners count as inside
    function bit in_tri(int px, int py, int a, int b, int c);
      if (edge_side(px, py, a, b) > 0) return 0;
      if (edge_side(px, py, b, c) > 0) return 0;
      if (edge_side(px, py, c, a) > 0) return 0;
      return 1;
    endfunction

    function bit same_pt(int k, int v);
      return vx[k] == vx[v] && vy[k] == vy[v];
    endfunction

    function void push_status(logic [2:0] st);
      rsp_t r;
      r = '0;
      r.status = st;
      pending = {pending, r};
    endfunction

    // ear tip b between neighbors a and c
    function void push_tri(int a, int b, int c);
      rsp_t r;
      if (tcount < NT) begin
        ta[tcount] = a;
        tb[tcount] = b;
        tc[tcount] = c;
        tcount++;
      end
      r = '0;
      r.status = ST_TRIANGLE;
      r.first_x = vx[a];
      r.first_y = vy[a];
      r.middle_x = vx[b];
      r.middle_y = vy[b];
      r.third_x = vx[c];
      r.third_y = vy[c];
      pending = {pending, r};
    endfunction

    // clip ears around the ring until three corners remain or a lap finds none
    function void clip_ring();
      int size, i, p, q, k, misses;
      bit ear;
      size = vcount;
      misses = 0;
      for (i = 0; i < size; i++) begin
        prv[i] = (i == 0) ? size - 1 : i - 1;
        nxt[i] = (i + 1 == size) ? 0 : i + 1;
      end
      i = 0;
      while (size > 3) begin
        p = prv[i];
        q = nxt[i];
        ear = edge_side(vx[i], vy[i], p, q) >= 0;
        if (ear) begin
          k = nxt[q];
          while (k != p) begin
            if (!same_pt(k, p) && !same_pt(k, i) && !same_pt(k, q) &&
                in_tri(vx[k], vy[k], p, i, q)) begin
              ear = 0;
              break;
            end
            k = nxt[k];
          end
        end
        if (ear) begin
          push_tri(p, i, q);
          nxt[p] = q;
          prv[q] = p;
          size--;
          misses = 0;
          i = p;
        end else begin
          misses++;
          if (misses >= size) begin
            push_status(ST_NO_EAR);
            return;
          end
          i = q;
        end
      end
      push_tri(prv[i], i, nxt[i]);
    endfunction

    // work out every result an accepted request causes
    function void note_request(req_t r);
      int x, y, t, mark;
      bit hit;
      rsp_t tail;
      x = r.x_coord;
      y = r.y_coord;
      mark = pending.size();
      case (r.opcode)
        OP_CLEAR: clear_all();
        OP_QUERY: begin
          hit = 0;
          for (t = 0; t < tcount && !hit; t++) hit = in_tri(x, y, ta[t], tb[t], tc[t]);
          push_status(hit ? ST_INSIDE : ST_OUTSIDE);
        end
        default: begin
          // append after a closed polygon starts a new one
          if (closed) clear_all();
          if (vcount >= NV) begin
            push_status(ST_OVERFLOW);
            if (r.opcode == OP_CLOSE) begin
              tcount = 0;
              closed = 1;
            end
          end else begin
            vx[vcount] = x;
            vy[vcount] = y;
            vcount++;
            if (r.opcode == OP_CLOSE) begin
              tcount = 0;
              closed = 1;
              if (vcount < 3) push_status(ST_TOO_FEW);
              else clip_ring();
            end
          end
        end
      endcase
      if (pending.size() > mark) begin
        tail = pending.pop_back();
        tail.last_of_run = 1'b1;
        pending = {pending, tail};
      end
    endfunction

    function void field_cmp(string name, longint e, longint a);
      if (e != a) begin
        errors++;
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual status %0d", $time, a.status);
        return;
      end
      e = pending.pop_front();
      results++;
      seen[e.status]++;
      field_cmp("status", e.status, a.status);
      field_cmp("first_x", e.first_x, a.first_x);
      field_cmp("first_y", e.first_y, a.first_y);
      field_cmp("middle_x", e.middle_x, a.middle_x);
      field_cmp("middle_y", e.middle_y, a.middle_y);
      field_cmp("third_x", e.third_x, a.third_x);
      field_cmp("third_y", e.third_y, a.third_y);
      field_cmp("last_of_run", e.last_of_run, a.last_of_run);
    endfunction
  endclass

  bit clk = 0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  triangle_board board = new();
  int sent = 0;
  bit hold = 0;          // long receiver hold-off to back up the request side
  longint cycles = 0;
  bit send_busy = 1, recv_busy = 1;  // idle modes; off means back-to-back

  ear_clipping_triangulator #(.MAX_VERTICES(NV)) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles,
               board.pending.size());
      $display("status: fail");
      $finish;
    end
  end

  function int pick_gap(bit busy);
    return busy ? $urandom_range(0, 16) : 0;
  endfunction

  // offer one request; valid holds until accepted, payload unchanged
  task send_req(logic [1:0] op, int x, int y);
    req_t r;
    int gap;
    r.opcode = op;
    r.x_coord = 16'(x);
    r.y_coord = 16'(y);
    if ($urandom_range(0, 19) == 0) send_busy = !send_busy;
    gap = pick_gap(send_busy);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.note_request(r);
    sent++;
  endtask

  // star-shaped polygon around a center, optionally wound clockwise
  task send_polygon(int n, bit cw, bit closing);
    int k, cx, cy, rad, px, py;
    real ang;
    cx = $urandom_range(0, 36000) - 18000;
    cy = $urandom_range(0, 36000) - 18000;
    rad = $urandom_range(4, 14000);
    for (k = 0; k < n; k++) begin
      ang = 6.2831853 * (k + 0.8 * ($urandom_range(0, 100) / 100.0 - 0.5)) / n;
      if (cw) ang = -ang;
      px = cx + $rtoi(rad * ($urandom_range(35, 100) / 100.0) * $cos(ang));
      py = cy + $rtoi(rad * ($urandom_range(35, 100) / 100.0) * $sin(ang));
      send_req((closing && k == n - 1) ? OP_CLOSE : OP_APPEND, px, py);
    end
  endtask

  // small grid polygon: many repeated and collinear points
  task send_grid_polygon(int n);
    int k;
    for (k = 0; k < n; k++)
      send_req(k == n - 1 ? OP_CLOSE : OP_APPEND, $urandom_range(0, 6), $urandom_range(0, 6));
  endtask

  task send_queries(int n);
    int k, sel;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 3);
      if (sel == 0 && board.vcount > 0)
        send_req(OP_QUERY, board.vx[$urandom_range(0, board.vcount - 1)],
                 board.vy[$urandom_range(0, board.vcount - 1)]);
      else if (sel == 1 && board.vcount > 0)
        send_req(OP_QUERY, board.vx[0] + $urandom_range(0, 400) - 200,
                 board.vy[0] + $urandom_range(0, 400) - 200);
      else if (sel == 2)
        send_req(OP_QUERY, $urandom_range(0, 6), $urandom_range(0, 6));
      else
        send_req(OP_QUERY, $signed(16'($urandom)), $signed(16'($urandom)));
    end
  endtask

  // receiver: random stalls per result, plus the hold-off window
  initial begin
    int n;
    rsp_ready = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0) recv_busy = !recv_busy;
      n = pick_gap(recv_busy);
      repeat (n) begin
        @(negedge clk);
        rsp_ready <= 1'b0;
      end
      @(negedge clk);
      while (hold) begin
        rsp_ready <= 1'b0;
        @(negedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      board.check_result(rsp);
    end
  end

  // hold the receiver off for a long stretch in the middle of the run
  initial begin
    wait (sent >= 150);
    hold = 1;
    repeat (600) @(posedge clk);
    hold = 0;
  end

  initial begin
    int n, kind;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: clear, empty query, too few vertices
    send_req(OP_CLEAR, 0, 0);
    send_req(OP_QUERY, 5, 5);
    send_req(OP_CLOSE, 1, 1);
    send_req(OP_APPEND, 0, 0);
    send_req(OP_CLOSE, 3, 3);
    // full-range triangle and queries on its corner and outside it
    send_req(OP_APPEND, -32768, -32768);
    send_req(OP_APPEND, 32767, -32768);
    send_req(OP_CLOSE, -32768, 32767);
    send_req(OP_QUERY, -32768, -32768);
    send_req(OP_QUERY, 0, 0);
    send_req(OP_QUERY, 32767, 32767);
    // square with a collinear midpoint, query on an edge
    send_req(OP_APPEND, 0, 0);
    send_req(OP_APPEND, 10, 0);
    send_req(OP_APPEND, 20, 0);
    send_req(OP_APPEND, 20, 20);
    send_req(OP_CLOSE, 0, 20);
    send_req(OP_QUERY, 20, 7);
    // clockwise square has no ear
    send_req(OP_APPEND, 0, 0);
    send_req(OP_APPEND, 0, 10);
    send_req(OP_APPEND, 10, 10);
    send_req(OP_CLOSE, 10, 0);
    // coincident vertices
    send_req(OP_APPEND, 0, 0);
    send_req(OP_APPEND, 10, 0);
    send_req(OP_APPEND, 10, 0);
    send_req(OP_CLOSE, 0, 10);

    // random: mostly well-formed polygons with queries, some noise
    while (sent < N_ITEMS) begin
      kind = $urandom_range(0, 19);
      if (kind < 11) begin
        send_polygon($urandom_range(3, 10), 0, 1);
        send_queries($urandom_range(0, 4));
      end else if (kind == 11) begin
        // full store, then appends that overflow
        send_polygon(NV, 0, 0);
        if ($urandom_range(0, 1)) send_req(OP_APPEND, 1, 2);
        send_req(OP_CLOSE, 3, 4);
        send_queries(1);
      end else if (kind == 12) begin
        send_polygon(NV, 0, 1);
        send_queries(2);
      end else if (kind < 15) begin
        send_grid_polygon($urandom_range(3, 7));
        send_queries($urandom_range(1, 3));
      end else if (kind == 15) begin
        send_polygon($urandom_range(4, 8), 1, 1);
      end else if (kind == 16) begin
        send_polygon($urandom_range(1, 2), 0, 1);
      end else if (kind == 17) begin
        send_req(OP_CLEAR, $signed(16'($urandom)), $signed(16'($urandom)));
        send_queries(1);
      end else begin
        n = $urandom_range(3, 8);
        repeat (n - 1) send_req(OP_APPEND, $signed(16'($urandom)), $signed(16'($urandom)));
        send_req(OP_CLOSE, $signed(16'($urandom)), $signed(16'($urandom)));
        send_queries($urandom_range(0, 2));
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results: %0d triangles, %0d inside, %0d outside",
             sent, board.results, board.seen[ST_TRIANGLE], board.seen[ST_INSIDE],
             board.seen[ST_OUTSIDE]);
    $display("guards hit: %0d no-ear, %0d too-few, %0d overflow; %0d errors",
             board.seen[ST_NO_EAR], board.seen[ST_TOO_FEW], board.seen[ST_OVERFLOW],
             board.errors);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[ear_clipping_triangulator.f]
hw/rtl/ect_pkg.sv
hw/rtl/ect_ram.sv
hw/rtl/ect_datapath.sv
hw/rtl/ect_ctrl.sv
hw/rtl/ear_clipping_triangulator.sv
tb/tb_ear_clipping_triangulator.sv
